// ===== hdl/lsdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsdrs_pkg: shared types and constants of the decimal radix sorter
// Widths, operation codes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

    localparam int DATA_W       = 31;
    localparam int RADIX        = 10;
    localparam int DIGITS       = 10;
    localparam int DIGIT_W      = 4;
    localparam int BCD_W        = DIGITS * DIGIT_W;
    localparam int PASS_W       = 4;
    localparam int BIT_W        = 5;
    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_HIST = 2'd1;
    localparam logic [1:0] OP_SCAT = 2'd2;
    localparam logic [1:0] OP_OUT  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       conv;
        logic       write;
        logic       set_ovf;
        logic       clr_cnt;
        logic       pfx;
        logic       flip;
        logic       clear_set;
        logic [1:0] rd_op;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic [PASS_W-1:0] npass;
    } t_status;

endpackage

// ===== hdl/lsdrs_datapath.sv =====
// ----------------------------------------------------------------------------
// lsdrs_datapath: storage and arithmetic of the decimal radix sorter
// Binary to decimal conversion, the ping-pong element memory, the ten
// digit counters, the element count, the running maximum and overflow.
// ----------------------------------------------------------------------------
module lsdrs_datapath #(
    parameter int CAPACITY = lsdrs_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [lsdrs_pkg::DATA_W-1:0]         i_value,
    input  lsdrs_pkg::t_cmd                      i_cmd,
    input  logic [$clog2(CAPACITY)-1:0]          i_idx,
    input  logic [lsdrs_pkg::PASS_W-1:0]         i_pass,
    input  logic [lsdrs_pkg::PASS_W-1:0]         i_k,
    output lsdrs_pkg::t_status                   o_status,
    output logic [$clog2(CAPACITY+1)-1:0]        o_count,
    output logic [lsdrs_pkg::DATA_W-1:0]         o_rdata,
    output logic                                 o_ovf
);
    import lsdrs_pkg::*;

    localparam int CW    = $clog2(CAPACITY);
    localparam int NW    = $clog2(CAPACITY + 1);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = DATA_W + BCD_W;

    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int j = 0; j < DIGITS; j++) begin
            if (r[j*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                r[j*DIGIT_W +: DIGIT_W] = r[j*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        return r;
    endfunction

    logic [EW-1:0]      mem [DEPTH];
    logic [EW-1:0]      r_rdata;
    logic [1:0]         r_op_d;
    logic [DATA_W-1:0]  r_val;
    logic [DATA_W-1:0]  r_sh;
    logic [BCD_W-1:0]   r_bcd;
    logic [DATA_W-1:0]  r_max;
    logic [BCD_W-1:0]   r_max_bcd;
    logic [NW-1:0]      r_count;
    logic               r_ovf;
    logic               r_bank;
    logic [NW-1:0]      r_cnt [RADIX];

    logic [DIGIT_W-1:0] digit;
    logic [NW-1:0]      pos;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;
    logic [BCD_W-1:0]   dab_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [PASS_W-1:0]  npass;

    assign digit   = r_rdata[DATA_W + i_pass*DIGIT_W +: DIGIT_W];
    assign pos     = r_cnt[digit] - NW'(1);
    assign dab_bcd = dabble(r_bcd);
    assign n_bcd   = {dab_bcd[BCD_W-2:0], r_sh[DATA_W-1]};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_bank, r_count[CW-1:0]};
        wr_data = {r_bcd, r_val};
        if (i_cmd.write) begin
            wr_en = 1'b1;
        end else if (r_op_d == OP_SCAT) begin
            wr_en   = 1'b1;
            wr_addr = {~r_bank, pos[CW-1:0]};
            wr_data = r_rdata;
        end
    end

    always_comb begin
        npass = '0;
        for (int j = 0; j < DIGITS; j++) begin
            if (r_max_bcd[j*DIGIT_W +: DIGIT_W] != '0) begin
                npass = PASS_W'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_op != OP_NONE) begin
            r_rdata <= mem[{r_bank, i_idx}];
        end
        if (i_cmd.load) begin
            r_val <= i_value;
            r_sh  <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.conv) begin
            r_sh  <= {r_sh[DATA_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_d    <= OP_NONE;
            r_max     <= '0;
            r_max_bcd <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_bank    <= 1'b0;
            for (int j = 0; j < RADIX; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            r_op_d <= i_cmd.rd_op;
            if (i_cmd.clear_set) begin
                r_max     <= '0;
                r_max_bcd <= '0;
                r_count   <= '0;
                r_ovf     <= 1'b0;
            end
            if (i_cmd.write) begin
                r_count <= r_count + NW'(1);
                if (r_val > r_max) begin
                    r_max     <= r_val;
                    r_max_bcd <= r_bcd;
                end
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.flip) begin
                r_bank <= ~r_bank;
            end
            if (i_cmd.clr_cnt) begin
                for (int j = 0; j < RADIX; j++) begin
                    r_cnt[j] <= '0;
                end
            end else if (i_cmd.pfx) begin
                r_cnt[i_k] <= r_cnt[i_k] + r_cnt[i_k - PASS_W'(1)];
            end else if (r_op_d == OP_HIST) begin
                r_cnt[digit] <= r_cnt[digit] + NW'(1);
            end else if (r_op_d == OP_SCAT) begin
                r_cnt[digit] <= pos;
            end
        end
    end

    assign o_status.full  = (r_count == NW'(CAPACITY));
    assign o_status.npass = npass;
    assign o_count        = r_count;
    assign o_rdata        = r_rdata[DATA_W-1:0];
    assign o_ovf          = r_ovf;

endmodule

// ===== hdl/lsdrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsdrs_ctrl: sequencer of the decimal radix sorter
// Steps loading, conversion, each counting, prefix and scatter pass,
// and the ordered readout, and drives the handshakes.
// ----------------------------------------------------------------------------
module lsdrs_ctrl #(
    parameter int CAPACITY = lsdrs_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_last_in,
    output logic                              o_stall,
    output logic                              o_valid,
    output logic                              o_last_out,
    input  logic                              i_stall,
    input  lsdrs_pkg::t_status                i_status,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    output lsdrs_pkg::t_cmd                   o_cmd,
    output logic [$clog2(CAPACITY)-1:0]       o_idx,
    output logic [lsdrs_pkg::PASS_W-1:0]      o_pass,
    output logic [lsdrs_pkg::PASS_W-1:0]      o_k
);
    import lsdrs_pkg::*;

    localparam int CW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CONV = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_PCLR = 4'd3;
    localparam logic [3:0] S_HIST = 4'd4;
    localparam logic [3:0] S_HDRN = 4'd5;
    localparam logic [3:0] S_PFX  = 4'd6;
    localparam logic [3:0] S_SCAT = 4'd7;
    localparam logic [3:0] S_SDRN = 4'd8;
    localparam logic [3:0] S_ORD  = 4'd9;
    localparam logic [3:0] S_OSH  = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [PASS_W-1:0] r_k, n_k;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_last, n_last;
    logic [NW-1:0]     last_n;
    logic [CW-1:0]     last_idx;

    assign last_n   = i_count - NW'(1);
    assign last_idx = last_n[CW-1:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pass  = r_pass;
        n_k     = r_k;
        n_bit   = r_bit;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_last_in;
                    if (i_status.full) begin
                        o_cmd.set_ovf = 1'b1;
                        n_state = i_last_in ? S_PCLR : S_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_bit   = BIT_W'(DATA_W - 1);
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.write = 1'b1;
                n_state = r_last ? S_PCLR : S_IDLE;
            end
            S_PCLR: begin
                o_cmd.clr_cnt = 1'b1;
                n_idx = '0;
                n_state = (r_pass == i_status.npass) ? S_ORD : S_HIST;
            end
            S_HIST: begin
                o_cmd.rd_op = OP_HIST;
                n_idx = r_idx + CW'(1);
                if (r_idx == last_idx) begin
                    n_state = S_HDRN;
                end
            end
            S_HDRN: begin
                n_k = PASS_W'(1);
                n_state = S_PFX;
            end
            S_PFX: begin
                o_cmd.pfx = 1'b1;
                n_k = r_k + PASS_W'(1);
                if (r_k == PASS_W'(RADIX - 1)) begin
                    n_idx = last_idx;
                    n_state = S_SCAT;
                end
            end
            S_SCAT: begin
                o_cmd.rd_op = OP_SCAT;
                n_idx = r_idx - CW'(1);
                if (r_idx == '0) begin
                    n_state = S_SDRN;
                end
            end
            S_SDRN: begin
                o_cmd.flip = 1'b1;
                n_pass = r_pass + PASS_W'(1);
                n_state = S_PCLR;
            end
            S_ORD: begin
                o_cmd.rd_op = OP_OUT;
                n_state = S_OSH;
            end
            S_OSH: begin
                if (!i_stall) begin
                    if (r_idx == last_idx) begin
                        o_cmd.clear_set = 1'b1;
                        n_pass = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pass  <= '0;
            r_k     <= '0;
            r_bit   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_k     <= n_k;
            r_bit   <= n_bit;
            r_last  <= n_last;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OSH);
    assign o_last_out = (r_idx == last_idx);
    assign o_idx      = r_idx;
    assign o_pass     = r_pass;
    assign o_k        = r_k;

endmodule

// ===== hdl/lsd_radix_sort_decimal.sv =====
// ----------------------------------------------------------------------------
// lsd_radix_sort_decimal: base ten least-significant-digit radix sorter
// Collects a set of words, sorts it by decimal digits and sends it out.
//
// Words enter on i_value and i_last_in with i_valid; the block raises
// o_stall while it is busy. Each accepted word is converted to decimal
// digits one bit a cycle and stored before the next word is accepted.
// A word that arrives with the store full is dropped and sets the
// overflow mark for the set. The word flagged i_last_in starts the sort:
// one pass for each decimal digit of the largest word, each reading every
// stored word twice, to count and to scatter, through the single read
// port of the element memory. The sorted set then leaves on o_sorted_value
// one word at a time, each after the last is taken, with o_last_out on
// the final word and o_overflow on every word of a set that lost words.
// While i_stall is high the output word holds. Reset empties the set.
// ----------------------------------------------------------------------------
module lsd_radix_sort_decimal #(
    parameter int CAPACITY = lsdrs_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lsdrs_pkg::DATA_W-1:0]  i_value,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsdrs_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflow
);
    import lsdrs_pkg::*;

    localparam int CW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    t_cmd              cmd;
    t_status           status;
    logic [CW-1:0]     idx;
    logic [PASS_W-1:0] pass;
    logic [PASS_W-1:0] k;
    logic [NW-1:0]     count;

    lsdrs_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_in  (i_last_in),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_last_out (o_last_out),
        .i_stall    (i_stall),
        .i_status   (status),
        .i_count    (count),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_pass     (pass),
        .o_k        (k)
    );

    lsdrs_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (cmd),
        .i_idx    (idx),
        .i_pass   (pass),
        .i_k      (k),
        .o_status (status),
        .o_count  (count),
        .o_rdata  (o_sorted_value),
        .o_ovf    (o_overflow)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the decimal radix sorter
// Sends sets of words with random sizes, values and gaps, predicts the
// sorted output of each set, including dropped words past capacity, and
// compares every output word field by field under random output stalls.
// ----------------------------------------------------------------------------
class sort_scoreboard;
    typedef struct packed {
        logic [30:0] value;
        logic        last;
        logic        ovf;
    } t_sorted_word;

    int unsigned       capacity;
    logic [30:0]       set_words[$];
    logic              set_dropped;
    t_sorted_word      sorted_pending[$];
    int                mismatches;
    int                words_checked;
    int                sets_done;

    function new(int unsigned cap);
        capacity = cap;
        set_dropped = 1'b0;
        mismatches = 0;
        words_checked = 0;
        sets_done = 0;
    endfunction

    function void note_input(logic [30:0] value, logic last);
        logic [30:0] work[$];
        logic [30:0] buckets[10][$];
        logic [30:0] top;
        longint unsigned place;
        t_sorted_word w;
        int n;
        int b;
        if (set_words.size() < capacity) begin
            set_words = {set_words, value};
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;
        work = set_words;
        top = 0;
        foreach (work[i]) if (work[i] > top) top = work[i];
        place = 1;
        while (longint'(top) / place > 0) begin
            for (int d = 0; d < 10; d++) buckets[d].delete();
            foreach (work[i]) begin
                b = int'((longint'(work[i]) / place) % 10);
                buckets[b] = {buckets[b], work[i]};
            end
            work.delete();
            for (int d = 0; d < 10; d++) work = {work, buckets[d]};
            place = place * 10;
        end
        n = work.size();
        foreach (work[i]) begin
            w.value = work[i];
            w.last = (i == n - 1);
            w.ovf = set_dropped;
            sorted_pending = {sorted_pending, w};
        end
        set_words.delete();
        set_dropped = 1'b0;
        sets_done++;
    endfunction

    function void check_output(logic [30:0] value, logic last, logic ovf);
        t_sorted_word w;
        words_checked++;
        if (sorted_pending.size() == 0) begin
            $error("unexpected output word: sorted_value %0d", value);
            mismatches++;
            return;
        end
        w = sorted_pending.pop_front();
        if (value !== w.value) begin
            $error("sorted_value: expected %0d, actual %0d", w.value, value);
            mismatches++;
        end
        if (last !== w.last) begin
            $error("last_out: expected %0b, actual %0b", w.last, last);
            mismatches++;
        end
        if (ovf !== w.ovf) begin
            $error("overflow: expected %0b, actual %0b", w.ovf, ovf);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    localparam int CAP = lsdrs_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [30:0] i_value;
    logic        i_last_in;
    logic        o_valid;
    logic        i_stall;
    logic [30:0] o_sorted_value;
    logic        o_last_out;
    logic        o_overflow;

    sort_scoreboard board;
    int unsigned    cycle_count = 0;
    bit             calm_stretch;
    int unsigned    words_sent;

    lsd_radix_sort_decimal uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_value(i_value), .i_last_in(i_last_in), .o_valid(o_valid),
        .i_stall(i_stall), .o_sorted_value(o_sorted_value),
        .o_last_out(o_last_out), .o_overflow(o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [30:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 9));
            1: return 31'($urandom_range(0, 999));
            2: return 31'h7FFFFFFF - 31'($urandom_range(0, 20));
            3: return 31'($urandom_range(0, 99999));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [30:0] value, logic last);
        while (!calm_stretch && $urandom_range(0, 99) < 19) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last_in <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(value, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_set(logic [30:0] vals[$]);
        foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.sorted_pending.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall)
            board.check_output(o_sorted_value, o_last_out, o_overflow);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !calm_stretch && ($urandom_range(0, 99) < 19);
        end
    end

    initial begin
        logic [30:0] vals[$];
        int n;
        board = new(CAP);
        words_sent = 0;
        calm_stretch = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_last_in = 1'b0;
        i_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_set('{31'd0});
        send_set('{31'd0, 31'd0, 31'd0});
        send_set('{31'h7FFFFFFF, 31'd0, 31'h55555555, 31'h2AAAAAAA, 31'd1});
        send_set('{31'd21, 31'd12, 31'd1000000000, 31'd12, 31'd9, 31'd10});
        send_set('{31'd7, 31'd7});
        wait_drained();

        vals.delete();
        for (int i = 0; i < CAP + 3; i++) vals = {vals, pick_value()};
        send_set(vals);

        while (words_sent < 105) begin
            calm_stretch = (words_sent > 84 && words_sent < 100);
            vals.delete();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) vals = {vals, pick_value()};
            send_set(vals);
        end
        calm_stretch = 1'b0;
        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("Sent %0d words in %0d sets, checked %0d sorted words.",
                 words_sent, board.sets_done, board.words_checked);
        if (board.mismatches == 0 && board.sorted_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule

// ===== filelist.f =====
hdl/lsdrs_pkg.sv
hdl/lsdrs_datapath.sv
hdl/lsdrs_ctrl.sv
hdl/lsd_radix_sort_decimal.sv
tb/testbench.sv
